### src/cba_pkg.sv
`timescale 1ns / 1ps
package cba_pkg;
   localparam int unsigned OPW = 31;
   localparam int unsigned RESW = 32;
   localparam int unsigned STEPS = 31;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_OP       = 3'd1,
      ST_TOO_LONG     = 3'd2,
      ST_MUL_TOO_LONG = 3'd3,
      ST_NOT_BINARY   = 3'd4,
      ST_DIV_ZERO     = 3'd5
   } status_type;

   // token carried down the chain
   typedef struct packed {
      logic             valid;
      logic [2:0]       status;
      logic             is_div;
      logic [RESW-1:0]  result;   // quotient bits shift in here on divide
      logic [OPW-1:0]   rem;      // partial remainder
      logic [OPW-1:0]   num;      // dividend bits still to consume
      logic [OPW-1:0]   den;
   } token_type;
endpackage

### src/cba_front.sv
`timescale 1ns / 1ps
module cba_front #(
   parameter int unsigned OPERAND_BITS = 31,
   parameter int unsigned MUL_OPERAND_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [2:0]                action,
   input  logic [cba_pkg::OPW-1:0]   a_value,
   input  logic [5:0]                a_length,
   input  logic                      a_not_binary,
   input  logic [cba_pkg::OPW-1:0]   b_value,
   input  logic [5:0]                b_length,
   input  logic                      b_not_binary,
   output cba_pkg::token_type        token_out
);
   cba_pkg::token_type token_ff, token_in;
   logic [31:0] prod;

   always_comb begin
      // only the low 32 bits of the product are kept
      prod = 32'(a_value) * 32'(b_value);
      token_in = '0;
      token_in.valid = take;
      token_in.den = b_value;
      token_in.num = a_value;
      if (action > 3'(cba_pkg::ACT_DIV)) begin
         token_in.status = cba_pkg::ST_BAD_OP;
      end else if (a_length > 6'(OPERAND_BITS) || b_length > 6'(OPERAND_BITS)) begin
         token_in.status = cba_pkg::ST_TOO_LONG;
      end else if (action == cba_pkg::ACT_MUL && (a_length > 6'(MUL_OPERAND_BITS)
                   || b_length > 6'(MUL_OPERAND_BITS))) begin
         token_in.status = cba_pkg::ST_MUL_TOO_LONG;
      end else if (a_not_binary || b_not_binary) begin
         token_in.status = cba_pkg::ST_NOT_BINARY;
      end else if (action == cba_pkg::ACT_DIV && b_value == '0) begin
         token_in.status = cba_pkg::ST_DIV_ZERO;
      end else begin
         token_in.status = cba_pkg::ST_OK;
         case (action)
            cba_pkg::ACT_ADD: token_in.result = 32'(a_value) + 32'(b_value);
            cba_pkg::ACT_SUB: token_in.result = (a_value >= b_value) ?
                                 32'(a_value - b_value) : '0;
            cba_pkg::ACT_MUL: token_in.result = prod;
            cba_pkg::ACT_DIV: token_in.is_div = 1'b1;
            default: token_in.result = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in;
      end
   end
   assign token_out = token_ff;
endmodule

### src/cba_cell.sv
`timescale 1ns / 1ps
module cba_cell (
   input  logic                clock,
   input  logic                reset,
   input  cba_pkg::token_type  token_in_port,
   output cba_pkg::token_type  token_out
);
   cba_pkg::token_type token_ff, token_in;
   logic [cba_pkg::OPW:0] trial;
   logic [cba_pkg::OPW:0] diff;

   // one restoring-division step per cell
   always_comb begin
      token_in = token_in_port;
      trial = {token_in_port.rem, token_in_port.num[cba_pkg::OPW-1]};
      diff = trial - {1'b0, token_in_port.den};
      if (token_in_port.is_div) begin
         token_in.num = {token_in_port.num[cba_pkg::OPW-2:0], 1'b0};
         if (!diff[cba_pkg::OPW]) begin
            token_in.rem = diff[cba_pkg::OPW-1:0];
            token_in.result = {token_in_port.result[cba_pkg::RESW-2:0], 1'b1};
         end else begin
            token_in.rem = trial[cba_pkg::OPW-1:0];
            token_in.result = {token_in_port.result[cba_pkg::RESW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in.valid;
      end
      token_ff.status <= token_in.status;
      token_ff.is_div <= token_in.is_div;
      token_ff.result <= token_in.result;
      token_ff.rem <= token_in.rem;
      token_ff.num <= token_in.num;
      token_ff.den <= token_in.den;
   end
   assign token_out = token_ff;
endmodule

### src/checked_binary_alu_unit.sv
`timescale 1ns / 1ps
// Checked binary ALU: add, clamped subtract, multiply, divide with remainder.
// Request: drive req_* fields with start high; a transfer happens when start
// is high and busy is low. busy is always low, so one request per cycle.
// Response: rsp_strobe marks rsp_status/rsp_result/rsp_remainder for one
// cycle; the receiver cannot stall and must take it then.
// Order: every operation passes the front register and every cell, so responses keep order.
// Throughput: one request per cycle. One front register does checks, add,
// subtract and multiply; a chain of 31 identical cells then does one
// restoring-division step each, other operations just pass along it.
// Status priority: bad operator, too long, multiply too long, not binary,
// divide by zero; on error result and remainder are zero.
// Reset: synchronous; clears all in-flight valid bits, requests lost.
module checked_binary_alu_unit #(
   parameter int unsigned OPERAND_BITS = 31,
   parameter int unsigned MUL_OPERAND_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_action,
   input  logic [cba_pkg::OPW-1:0]   req_a_value,
   input  logic [5:0]                req_a_length,
   input  logic                      req_a_not_binary,
   input  logic [cba_pkg::OPW-1:0]   req_b_value,
   input  logic [5:0]                req_b_length,
   input  logic                      req_b_not_binary,
   output logic                      rsp_strobe,
   output logic [2:0]                rsp_status,
   output logic [cba_pkg::RESW-1:0]  rsp_result,
   output logic [cba_pkg::OPW-1:0]   rsp_remainder
);
   cba_pkg::token_type chain [0:cba_pkg::STEPS];

   assign busy = 1'b0;

   cba_front #(.OPERAND_BITS(OPERAND_BITS), .MUL_OPERAND_BITS(MUL_OPERAND_BITS)) u_front (
      .clock(clock), .reset(reset), .take(start && !busy),
      .action(req_action), .a_value(req_a_value), .a_length(req_a_length),
      .a_not_binary(req_a_not_binary), .b_value(req_b_value),
      .b_length(req_b_length), .b_not_binary(req_b_not_binary),
      .token_out(chain[0])
   );

   for (genvar i = 0; i < cba_pkg::STEPS; i++) begin : g_cell
      cba_cell u_cell (
         .clock(clock), .reset(reset),
         .token_in_port(chain[i]), .token_out(chain[i+1])
      );
   end

   assign rsp_strobe = chain[cba_pkg::STEPS].valid;
   assign rsp_status = chain[cba_pkg::STEPS].status;
   assign rsp_result = chain[cba_pkg::STEPS].result;
   assign rsp_remainder = chain[cba_pkg::STEPS].is_div ? chain[cba_pkg::STEPS].rem : '0;
endmodule

### src/cba_checker.sv
`timescale 1ns / 1ps
module cba_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_result,
   input logic [30:0] rsp_remainder
);
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != 3'd0 |-> rsp_result == '0 && rsp_remainder == '0)
      else $error("error response with nonzero data");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status <= 3'd5)
      else $error("status out of range");
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_reset_quiet: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_strobe)
      else $error("strobe right after reset");
endmodule

bind checked_binary_alu_unit cba_checker u_cba_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
   .rsp_result(rsp_result), .rsp_remainder(rsp_remainder)
);

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   localparam int unsigned OPW = cba_pkg::OPW;
   localparam int unsigned RESW = cba_pkg::RESW;
   localparam int unsigned BAD_OP_CODE = 4;
   localparam int unsigned LATENCY = 32;
   localparam int unsigned RANDOM_OPS = 600;

   typedef struct {
      logic [2:0]      action;
      logic [OPW-1:0]  a_value;
      logic [5:0]      a_length;
      logic            a_not_binary;
      logic [OPW-1:0]  b_value;
      logic [5:0]      b_length;
      logic            b_not_binary;
   } alu_op_type;

   typedef struct {
      logic [2:0]      status;
      logic [RESW-1:0] result;
      logic [OPW-1:0]  remainder;
   } alu_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_action = '0;
   logic [OPW-1:0] req_a_value = '0;
   logic [5:0] req_a_length = '0;
   logic req_a_not_binary = 1'b0;
   logic [OPW-1:0] req_b_value = '0;
   logic [5:0] req_b_length = '0;
   logic req_b_not_binary = 1'b0;
   logic rsp_strobe;
   logic [2:0] rsp_status;
   logic [RESW-1:0] rsp_result;
   logic [OPW-1:0] rsp_remainder;

   alu_answer_type pending_answers[$];
   int unsigned error_count = 0;

   checked_binary_alu_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_a_value(req_a_value),
      .req_a_length(req_a_length), .req_a_not_binary(req_a_not_binary),
      .req_b_value(req_b_value), .req_b_length(req_b_length),
      .req_b_not_binary(req_b_not_binary),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_result(rsp_result), .rsp_remainder(rsp_remainder)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic alu_answer_type compute_answer(alu_op_type op);
      alu_answer_type ans;
      logic [63:0] prod;
      ans = '{status: cba_pkg::ST_OK, result: '0, remainder: '0};
      if (op.action > cba_pkg::ACT_DIV)
         ans.status = cba_pkg::ST_BAD_OP;
      else if (op.a_length > 31 || op.b_length > 31)
         ans.status = cba_pkg::ST_TOO_LONG;
      else if (op.action == cba_pkg::ACT_MUL && (op.a_length > 16 || op.b_length > 16))
         ans.status = cba_pkg::ST_MUL_TOO_LONG;
      else if (op.a_not_binary || op.b_not_binary)
         ans.status = cba_pkg::ST_NOT_BINARY;
      else if (op.action == cba_pkg::ACT_DIV && op.b_value == 0)
         ans.status = cba_pkg::ST_DIV_ZERO;
      else begin
         case (op.action)
            cba_pkg::ACT_ADD: ans.result = {1'b0, op.a_value} + {1'b0, op.b_value};
            cba_pkg::ACT_SUB: ans.result = (op.a_value >= op.b_value) ?
                                  {1'b0, op.a_value - op.b_value} : '0;
            cba_pkg::ACT_MUL: begin
               prod = 64'(op.a_value) * 64'(op.b_value);
               ans.result = prod[31:0];
            end
            default: begin
               ans.result = {1'b0, op.a_value / op.b_value};
               ans.remainder = op.a_value % op.b_value;
            end
         endcase
      end
      return ans;
   endfunction

   task automatic send_op(alu_op_type op);
      int unsigned gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= op.action;
      req_a_value <= op.a_value;
      req_a_length <= op.a_length;
      req_a_not_binary <= op.a_not_binary;
      req_b_value <= op.b_value;
      req_b_length <= op.b_length;
      req_b_not_binary <= op.b_not_binary;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_answers.push_back(compute_answer(op));
   endtask

   // transfer check on the result side
   always @(posedge clock) begin
      alu_answer_type exp_ans;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result status=%0d result=%0h rem=%0h",
                     $time, rsp_status, rsp_result, rsp_remainder);
            error_count++;
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_status !== exp_ans.status) begin
               $display("%0t: status expected %0d got %0d",
                        $time, exp_ans.status, rsp_status);
               error_count++;
            end
            if (rsp_result !== exp_ans.result) begin
               $display("%0t: result expected %0h got %0h",
                        $time, exp_ans.result, rsp_result);
               error_count++;
            end
            if (rsp_remainder !== exp_ans.remainder) begin
               $display("%0t: remainder expected %0h got %0h",
                        $time, exp_ans.remainder, rsp_remainder);
               error_count++;
            end
         end
      end
   end

   function automatic alu_op_type random_op();
      alu_op_type op;
      int unsigned pick;
      op.action = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(4, 7))
                                               : 3'($urandom_range(0, 3));
      pick = $urandom_range(0, 3);
      op.a_value = (pick == 0) ? OPW'($urandom_range(0, 255)) : OPW'($urandom);
      pick = $urandom_range(0, 3);
      op.b_value = (pick == 0) ? OPW'($urandom_range(0, 255)) : OPW'($urandom);
      if (op.action == cba_pkg::ACT_MUL && $urandom_range(0, 1)) begin
         op.a_value = OPW'($urandom_range(0, 16'hffff));
         op.b_value = OPW'($urandom_range(0, 16'hffff));
      end
      if (op.action == cba_pkg::ACT_DIV && $urandom_range(0, 7) == 0)
         op.b_value = '0;
      // mostly legal lengths, occasionally any length
      if ($urandom_range(0, 7) == 0) begin
         op.a_length = 6'($urandom);
         op.b_length = 6'($urandom);
      end else begin
         op.a_length = 6'($urandom_range(0, (op.action == cba_pkg::ACT_MUL) ? 16 : 31));
         op.b_length = 6'($urandom_range(0, (op.action == cba_pkg::ACT_MUL) ? 16 : 31));
      end
      op.a_not_binary = ($urandom_range(0, 15) == 0);
      op.b_not_binary = ($urandom_range(0, 15) == 0);
      return op;
   endfunction

   typedef struct {
      alu_op_type     op;
      bit             has_answer;
      alu_answer_type answer;
   } directed_row_type;

   localparam logic [OPW-1:0] VMAX = '1;

   directed_row_type directed_rows[] = '{
      '{'{cba_pkg::ACT_ADD, VMAX, 6'd31, 1'b0, VMAX, 6'd31, 1'b0}, 1'b1,
        '{cba_pkg::ST_OK, 32'hffff_fffe, 31'd0}},
      '{'{cba_pkg::ACT_ADD, 31'd0, 6'd0, 1'b0, 31'd0, 6'd0, 1'b0}, 1'b1,
        '{cba_pkg::ST_OK, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_SUB, 31'd5, 6'd3, 1'b0, 31'd9, 6'd4, 1'b0}, 1'b1,
        '{cba_pkg::ST_OK, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_SUB, VMAX, 6'd31, 1'b0, 31'd1, 6'd1, 1'b0}, 1'b0,
        '{cba_pkg::ST_OK, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_MUL, 31'hffff, 6'd16, 1'b0, 31'hffff, 6'd16, 1'b0}, 1'b1,
        '{cba_pkg::ST_OK, 32'hfffe_0001, 31'd0}},
      '{'{cba_pkg::ACT_MUL, VMAX, 6'd16, 1'b0, VMAX, 6'd16, 1'b0}, 1'b0,
        '{cba_pkg::ST_OK, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_MUL, 31'd3, 6'd17, 1'b0, 31'd3, 6'd2, 1'b0}, 1'b1,
        '{cba_pkg::ST_MUL_TOO_LONG, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_MUL, 31'd3, 6'd2, 1'b0, 31'd3, 6'd17, 1'b0}, 1'b1,
        '{cba_pkg::ST_MUL_TOO_LONG, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_DIV, VMAX, 6'd31, 1'b0, 31'd7, 6'd3, 1'b0}, 1'b0,
        '{cba_pkg::ST_OK, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_DIV, 31'd100, 6'd7, 1'b0, 31'd0, 6'd1, 1'b0}, 1'b1,
        '{cba_pkg::ST_DIV_ZERO, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_DIV, VMAX, 6'd31, 1'b0, VMAX, 6'd31, 1'b0}, 1'b1,
        '{cba_pkg::ST_OK, 32'd1, 31'd0}},
      '{'{cba_pkg::ACT_DIV, 31'd0, 6'd1, 1'b0, 31'd1, 6'd1, 1'b0}, 1'b1,
        '{cba_pkg::ST_OK, 32'd0, 31'd0}},
      '{'{3'(BAD_OP_CODE), 31'd1, 6'd1, 1'b1, 31'd0, 6'd63, 1'b1}, 1'b1,
        '{cba_pkg::ST_BAD_OP, 32'd0, 31'd0}},
      '{'{3'd5, 31'd1, 6'd1, 1'b0, 31'd1, 6'd1, 1'b0}, 1'b1,
        '{cba_pkg::ST_BAD_OP, 32'd0, 31'd0}},
      '{'{3'd7, 31'd1, 6'd1, 1'b0, 31'd1, 6'd1, 1'b0}, 1'b1,
        '{cba_pkg::ST_BAD_OP, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_ADD, 31'd1, 6'd32, 1'b0, 31'd1, 6'd1, 1'b0}, 1'b1,
        '{cba_pkg::ST_TOO_LONG, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_MUL, 31'd1, 6'd1, 1'b1, 31'd1, 6'd63, 1'b0}, 1'b1,
        '{cba_pkg::ST_TOO_LONG, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_MUL, 31'd1, 6'd20, 1'b1, 31'd1, 6'd1, 1'b0}, 1'b1,
        '{cba_pkg::ST_MUL_TOO_LONG, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_ADD, 31'd1, 6'd1, 1'b1, 31'd1, 6'd1, 1'b0}, 1'b1,
        '{cba_pkg::ST_NOT_BINARY, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_DIV, 31'd1, 6'd1, 1'b0, 31'd0, 6'd1, 1'b1}, 1'b1,
        '{cba_pkg::ST_NOT_BINARY, 32'd0, 31'd0}},
      '{'{cba_pkg::ACT_ADD, 31'd12, 6'd4, 1'b0, 31'd5, 6'd3, 1'b0}, 1'b1,
        '{cba_pkg::ST_OK, 32'd17, 31'd0}},
      '{'{cba_pkg::ACT_DIV, 31'd10, 6'd4, 1'b0, 31'd3, 6'd2, 1'b0}, 1'b1,
        '{cba_pkg::ST_OK, 32'd3, 31'd1}}
   };

   initial begin
      int unsigned guard;
      alu_answer_type pred;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].has_answer) begin
            pred = compute_answer(directed_rows[i].op);
            if (pred.status !== directed_rows[i].answer.status ||
                pred.result !== directed_rows[i].answer.result ||
                pred.remainder !== directed_rows[i].answer.remainder) begin
               $display("%0t: table row %0d expected %p, predictor %p",
                        $time, i, directed_rows[i].answer, pred);
               error_count++;
            end
         end
         send_op(directed_rows[i].op);
      end
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == RANDOM_OPS / 2) begin
            // drain the pipe once before continuing
            start <= 1'b0;
            while (pending_answers.size() != 0) @(posedge clock);
         end
         send_op(random_op());
      end
      start <= 1'b0;
      guard = 0;
      while (pending_answers.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
